[hw/rtl/frs_pkg.sv]
package frs_pkg;

  localparam int unsigned AddrW = 5;
  localparam int unsigned DataW = 32;

  localparam logic [7:0]  HardSrcMask  = 8'h05;
  localparam logic [7:0]  SoftSrcMask  = 8'h0A;
  localparam logic [15:0] VoltMinQ88   = 16'd256;
  localparam logic [15:0] VoltMaxQ88   = 16'd15360;
  localparam logic [16:0] VoltMargin   = 17'd128;

  localparam logic [15:0] RstStartDelay = 16'd500;
  localparam logic [15:0] RstCooldown   = 16'd1000;
  localparam logic [7:0]  RstMaxActions = 8'd3;
  localparam logic [15:0] RstBootWindow = 16'd3000;
  localparam logic [15:0] RstNominal    = 16'd6144;
  localparam logic [3:0]  RstFeatures   = 4'hF;

  localparam int unsigned FeatVolt    = 0;
  localparam int unsigned FeatFault   = 1;
  localparam int unsigned FeatOutput  = 2;
  localparam int unsigned FeatLoop    = 3;

  typedef enum logic [2:0] {
    REG_START_DELAY = 3'd0,
    REG_COOLDOWN    = 3'd1,
    REG_MAX_ACTIONS = 3'd2,
    REG_BOOT_WINDOW = 3'd3,
    REG_NOMINAL     = 3'd4,
    REG_FEATURES    = 3'd5
  } reg_idx_e;

  // also used for the refusal code: same numbering
  typedef enum logic [1:0] {
    ACT_NONE         = 2'd0,
    ACT_CLEAR_FAULT  = 2'd1,
    ACT_ENABLE_OUT   = 2'd2,
    ACT_RESTART_LOOP = 2'd3
  } action_e;

  typedef enum logic [2:0] {
    CAUSE_NONE    = 3'd0,
    CAUSE_FAULT   = 3'd1,
    CAUSE_OUTPUT  = 3'd2,
    CAUSE_LOOP    = 3'd3,
    CAUSE_VOLTAGE = 3'd4
  } cause_e;

  typedef struct packed {
    logic [15:0] start_delay;
    logic [15:0] cooldown;
    logic [7:0]  max_actions;
    logic [15:0] boot_window;
    logic [15:0] nominal;
    logic [3:0]  features;
  } cfg_t;

endpackage

[hw/rtl/frs_if.sv]
interface frs_in_if;
  logic        valid;
  logic        ready;
  logic        fault_latched;
  logic        output_enabled;
  logic        loop_failed;
  logic [7:0]  fault_sources;
  logic [15:0] bus_sample;

  modport source (
    output valid, fault_latched, output_enabled, loop_failed, fault_sources, bus_sample,
    input  ready
  );
  modport sink (
    input  valid, fault_latched, output_enabled, loop_failed, fault_sources, bus_sample,
    output ready
  );
endinterface

interface frs_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  action;
  logic        bus_updated;
  logic [15:0] bus_value;
  logic [1:0]  blocked_code;
  logic [2:0]  last_cause;
  logic [15:0] actions_done;

  modport source (
    output valid, action, bus_updated, bus_value, blocked_code, last_cause, actions_done,
    input  ready
  );
  modport sink (
    input  valid, action, bus_updated, bus_value, blocked_code, last_cause, actions_done,
    output ready
  );
endinterface

[hw/rtl/frs_regs.sv]
module frs_regs (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [frs_pkg::AddrW-1:0]     paddr,
  input  logic [frs_pkg::DataW-1:0]     pwdata,
  output logic [frs_pkg::DataW-1:0]     prdata,
  output logic                          pready,
  output frs_pkg::cfg_t                 cfg_o
);

  frs_pkg::cfg_t      cfg_q, cfg_d;
  frs_pkg::reg_idx_e  idx;
  logic               wr_en;

  assign idx    = frs_pkg::reg_idx_e'(paddr[frs_pkg::AddrW-1:2]);
  assign wr_en  = psel & penable & pwrite;
  assign pready = 1'b1;
  assign cfg_o  = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      case (idx)
        frs_pkg::REG_START_DELAY: cfg_d.start_delay = pwdata[15:0];
        frs_pkg::REG_COOLDOWN:    cfg_d.cooldown    = pwdata[15:0];
        frs_pkg::REG_MAX_ACTIONS: cfg_d.max_actions = pwdata[7:0];
        frs_pkg::REG_BOOT_WINDOW: cfg_d.boot_window = pwdata[15:0];
        frs_pkg::REG_NOMINAL:     cfg_d.nominal     = pwdata[15:0];
        frs_pkg::REG_FEATURES:    cfg_d.features    = pwdata[3:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      frs_pkg::REG_START_DELAY: prdata = {16'd0, cfg_q.start_delay};
      frs_pkg::REG_COOLDOWN:    prdata = {16'd0, cfg_q.cooldown};
      frs_pkg::REG_MAX_ACTIONS: prdata = {24'd0, cfg_q.max_actions};
      frs_pkg::REG_BOOT_WINDOW: prdata = {16'd0, cfg_q.boot_window};
      frs_pkg::REG_NOMINAL:     prdata = {16'd0, cfg_q.nominal};
      frs_pkg::REG_FEATURES:    prdata = {28'd0, cfg_q.features};
      default:                  prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.start_delay <= frs_pkg::RstStartDelay;
      cfg_q.cooldown    <= frs_pkg::RstCooldown;
      cfg_q.max_actions <= frs_pkg::RstMaxActions;
      cfg_q.boot_window <= frs_pkg::RstBootWindow;
      cfg_q.nominal     <= frs_pkg::RstNominal;
      cfg_q.features    <= frs_pkg::RstFeatures;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

[hw/rtl/fault_recovery_supervisor.sv]
// Fault recovery supervisor. Each transfer on tick_i is one millisecond tick of fault status
// and a bus-voltage sample; each yields exactly one transfer on result_o carrying the chosen
// recovery action, an optional one-time bus-voltage correction, the last refusal, the last
// cause and the saturating action count. A tick is registered on entry; its result is
// registered in the result register when that is empty or being taken. A new tick is taken
// every cycle unless the result output stalls, the rate being set by the single decision stage
// that reads and updates the tick counter, cooldown end and action budget together. Registers sit
// on the APB port at byte addresses 4*i and should only be written while no tick is in flight.
module fault_recovery_supervisor (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  frs_in_if.sink                    tick_i,
  frs_out_if.source                 result_o,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [frs_pkg::AddrW-1:0] paddr,
  input  logic [frs_pkg::DataW-1:0] pwdata,
  output logic [frs_pkg::DataW-1:0] prdata,
  output logic                      pready
);

  frs_pkg::cfg_t cfg;

  frs_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // input register
  logic        in_vld_q;
  logic        latched_q, enabled_q, failed_q;
  logic [7:0]  src_q;
  logic [15:0] sample_q;

  // supervision state
  logic [31:0] tick_q, tick_d;
  logic [31:0] cool_end_q, cool_end_d;
  logic [15:0] total_q, total_d;
  logic        vchk_q, vchk_d;
  logic        soft_used_q, soft_used_d;
  frs_pkg::action_e blocked_q, blocked_d;
  frs_pkg::cause_e  cause_q, cause_d;

  // result register
  logic             out_vld_q;
  frs_pkg::action_e act_q, act_d;
  logic             upd_q, upd_d;
  logic [15:0]      bval_q, bval_d;

  logic advance, in_ready;
  logic active, vchk_do, v_ok, cool_ok;
  logic c_fault, c_out, c_loop, any_cand;
  logic budget, hard, soft_hit, soft_path, gate;

  assign advance  = in_vld_q & (~out_vld_q | result_o.ready);
  assign in_ready = ~in_vld_q | advance;
  assign tick_i.ready = in_ready;

  always_comb begin
    tick_d  = tick_q + 32'd1;
    active  = tick_d >= {16'd0, cfg.start_delay};
    vchk_do = active & cfg.features[frs_pkg::FeatVolt] & ~vchk_q;
    v_ok    = (sample_q > frs_pkg::VoltMinQ88) && (sample_q < frs_pkg::VoltMaxQ88) &&
              ({1'b0, sample_q} > ({1'b0, cfg.nominal} + frs_pkg::VoltMargin));
    upd_d   = vchk_do & v_ok;
    bval_d  = upd_d ? sample_q : 16'd0;
    vchk_d  = vchk_q | vchk_do;

    cool_ok  = active & (tick_d >= cool_end_q);
    c_fault  = cool_ok & cfg.features[frs_pkg::FeatFault] & latched_q;
    c_out    = cool_ok & cfg.features[frs_pkg::FeatOutput] & ~enabled_q;
    c_loop   = cool_ok & cfg.features[frs_pkg::FeatLoop] & failed_q;
    any_cand = c_fault | c_out | c_loop;

    budget    = (cfg.max_actions == 8'd0) || (total_q < {8'd0, cfg.max_actions});
    hard      = |(src_q & frs_pkg::HardSrcMask);
    soft_hit  = |(src_q & frs_pkg::SoftSrcMask);
    soft_path = ~hard & soft_hit & ~soft_used_q & (tick_d <= {16'd0, cfg.boot_window});
    gate      = budget & ((src_q == 8'd0) | soft_path);

    act_d = frs_pkg::ACT_NONE;
    if (gate && any_cand) begin
      if (c_fault)    act_d = frs_pkg::ACT_CLEAR_FAULT;
      else if (c_out) act_d = frs_pkg::ACT_ENABLE_OUT;
      else            act_d = frs_pkg::ACT_RESTART_LOOP;
    end

    // a refusal leaves the state alone, so the lowest-priority candidate is recorded last
    blocked_d = blocked_q;
    if (!gate && any_cand) begin
      if (c_loop)     blocked_d = frs_pkg::ACT_RESTART_LOOP;
      else if (c_out) blocked_d = frs_pkg::ACT_ENABLE_OUT;
      else            blocked_d = frs_pkg::ACT_CLEAR_FAULT;
    end

    soft_used_d = soft_used_q | (gate & any_cand & (src_q != 8'd0));

    cause_d    = cause_q;
    total_d    = total_q;
    cool_end_d = cool_end_q;
    if (upd_d) cause_d = frs_pkg::CAUSE_VOLTAGE;
    if (act_d != frs_pkg::ACT_NONE) begin
      cause_d    = frs_pkg::cause_e'({1'b0, act_d});
      total_d    = (total_q != 16'hFFFF) ? total_q + 16'd1 : total_q;
      cool_end_d = tick_d + {16'd0, cfg.cooldown};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q    <= 1'b0;
      out_vld_q   <= 1'b0;
      tick_q      <= '0;
      cool_end_q  <= '0;
      total_q     <= '0;
      vchk_q      <= 1'b0;
      soft_used_q <= 1'b0;
      blocked_q   <= frs_pkg::ACT_NONE;
      cause_q     <= frs_pkg::CAUSE_NONE;
    end else begin
      if (in_ready) in_vld_q <= tick_i.valid;
      if (advance) begin
        out_vld_q   <= 1'b1;
        tick_q      <= tick_d;
        cool_end_q  <= cool_end_d;
        total_q     <= total_d;
        vchk_q      <= vchk_d;
        soft_used_q <= soft_used_d;
        blocked_q   <= blocked_d;
        cause_q     <= cause_d;
      end else if (result_o.ready) begin
        out_vld_q   <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready && tick_i.valid) begin
      latched_q <= tick_i.fault_latched;
      enabled_q <= tick_i.output_enabled;
      failed_q  <= tick_i.loop_failed;
      src_q     <= tick_i.fault_sources;
      sample_q  <= tick_i.bus_sample;
    end
    if (advance) begin
      act_q  <= act_d;
      upd_q  <= upd_d;
      bval_q <= bval_d;
    end
  end

  assign result_o.valid        = out_vld_q;
  assign result_o.action       = act_q;
  assign result_o.bus_updated  = upd_q;
  assign result_o.bus_value    = bval_q;
  assign result_o.blocked_code = blocked_q;
  assign result_o.last_cause   = cause_q;
  assign result_o.actions_done = total_q;

endmodule

[hw/rtl/frs_checker.sv]
module frs_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid,
  input logic        out_ready,
  input logic [1:0]  action,
  input logic        bus_updated,
  input logic [15:0] bus_value,
  input logic [2:0]  last_cause,
  input logic [15:0] actions_done
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid && $stable(action) && $stable(bus_value) &&
      $stable(last_cause) && $stable(actions_done))
    else $error("result changed while stalled");

  a_act_counted: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && action != frs_pkg::ACT_NONE |-> actions_done != 16'd0)
    else $error("action without count");

  a_bus_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !bus_updated |-> bus_value == 16'd0)
    else $error("bus value without update");

  a_cause_act: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && action != frs_pkg::ACT_NONE |-> last_cause == {1'b0, action})
    else $error("cause does not match action");

endmodule

bind fault_recovery_supervisor frs_checker u_frs_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .out_valid    (result_o.valid),
  .out_ready    (result_o.ready),
  .action       (result_o.action),
  .bus_updated  (result_o.bus_updated),
  .bus_value    (result_o.bus_value),
  .last_cause   (result_o.last_cause),
  .actions_done (result_o.actions_done)
);

[sim/fault_recovery_supervisor_tb.sv]
module fault_recovery_supervisor_tb;

  localparam int unsigned CycleLimit = 1_000_000;
  localparam logic [2:0]  RegUnmapped = 3'd6;

  typedef struct packed {
    logic        fault_latched;
    logic        output_enabled;
    logic        loop_failed;
    logic [7:0]  fault_sources;
    logic [15:0] bus_sample;
  } tick_t;

  typedef struct packed {
    frs_pkg::action_e action;
    logic             bus_updated;
    logic [15:0]      bus_value;
    frs_pkg::action_e blocked_code;
    frs_pkg::cause_e  last_cause;
    logic [15:0]      actions_done;
  } verdict_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  logic                      psel;
  logic                      penable;
  logic                      pwrite;
  logic [frs_pkg::AddrW-1:0] paddr;
  logic [frs_pkg::DataW-1:0] pwdata;
  logic [frs_pkg::DataW-1:0] prdata;
  logic                      pready;

  frs_in_if  tick_bus ();
  frs_out_if result_bus ();

  fault_recovery_supervisor dut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .tick_i   (tick_bus),
    .result_o (result_bus),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  always #1 clk_i = ~clk_i;

  // supervisor state as the block should hold it
  frs_pkg::cfg_t    cfg;
  logic [31:0]      elapsed_ticks;
  logic [31:0]      quiet_until;
  logic [15:0]      recoveries;
  logic             bus_checked;
  logic             retry_spent;
  frs_pkg::action_e last_refusal;
  frs_pkg::cause_e  last_reason;

  tick_t       stim_q[$];
  verdict_t    verdict_q[$];
  tick_t       next_tick;
  verdict_t    want;

  int unsigned send_gap_pct;
  int unsigned recv_stall_pct;
  int unsigned ticks_queued;
  int unsigned ticks_sent;
  int unsigned results_seen;
  int unsigned actions_seen;
  int unsigned bus_fixes_seen;
  int unsigned settings_used;
  int unsigned fails;
  int unsigned cycle_count = 0;

  function automatic logic recovery_permitted(logic [7:0] src);
    if (cfg.max_actions != 8'd0 && recoveries >= 16'(cfg.max_actions)) return 1'b0;
    if (src == 8'h00) return 1'b1;
    if ((src & frs_pkg::HardSrcMask) != 8'h00) return 1'b0;
    if ((src & frs_pkg::SoftSrcMask) == 8'h00) return 1'b0;
    if (retry_spent || elapsed_ticks > 32'(cfg.boot_window)) return 1'b0;
    retry_spent = 1'b1;
    return 1'b1;
  endfunction

  function automatic verdict_t supervise_tick(tick_t t);
    verdict_t         v;
    frs_pkg::action_e pick;
    v = '0;
    pick = frs_pkg::ACT_NONE;
    elapsed_ticks = elapsed_ticks + 32'd1;
    if (elapsed_ticks >= 32'(cfg.start_delay)) begin
      if (cfg.features[frs_pkg::FeatVolt] && !bus_checked) begin
        if (t.bus_sample > frs_pkg::VoltMinQ88 && t.bus_sample < frs_pkg::VoltMaxQ88 &&
            17'(t.bus_sample) > 17'(cfg.nominal) + frs_pkg::VoltMargin) begin
          v.bus_updated = 1'b1;
          v.bus_value   = t.bus_sample;
          last_reason   = frs_pkg::CAUSE_VOLTAGE;
        end
        bus_checked = 1'b1;
      end
      if (elapsed_ticks >= quiet_until) begin
        // priority: fault latch, then outputs, then loop; a refusal falls through
        if (cfg.features[frs_pkg::FeatFault] && t.fault_latched) begin
          if (recovery_permitted(t.fault_sources)) pick = frs_pkg::ACT_CLEAR_FAULT;
          else last_refusal = frs_pkg::ACT_CLEAR_FAULT;
        end
        if (pick == frs_pkg::ACT_NONE && cfg.features[frs_pkg::FeatOutput] &&
            !t.output_enabled) begin
          if (recovery_permitted(t.fault_sources)) pick = frs_pkg::ACT_ENABLE_OUT;
          else last_refusal = frs_pkg::ACT_ENABLE_OUT;
        end
        if (pick == frs_pkg::ACT_NONE && cfg.features[frs_pkg::FeatLoop] && t.loop_failed) begin
          if (recovery_permitted(t.fault_sources)) pick = frs_pkg::ACT_RESTART_LOOP;
          else last_refusal = frs_pkg::ACT_RESTART_LOOP;
        end
        if (pick != frs_pkg::ACT_NONE) begin
          last_reason = frs_pkg::cause_e'(pick);
          if (recoveries != 16'hFFFF) recoveries = recoveries + 16'd1;
          quiet_until = elapsed_ticks + 32'(cfg.cooldown);
        end
      end
    end
    v.action       = pick;
    v.blocked_code = last_refusal;
    v.last_cause   = last_reason;
    v.actions_done = recoveries;
    return v;
  endfunction

  function automatic logic [31:0] mirror_value(logic [2:0] idx);
    case (idx)
      frs_pkg::REG_START_DELAY: return 32'(cfg.start_delay);
      frs_pkg::REG_COOLDOWN:    return 32'(cfg.cooldown);
      frs_pkg::REG_MAX_ACTIONS: return 32'(cfg.max_actions);
      frs_pkg::REG_BOOT_WINDOW: return 32'(cfg.boot_window);
      frs_pkg::REG_NOMINAL:     return 32'(cfg.nominal);
      frs_pkg::REG_FEATURES:    return 32'(cfg.features);
      default:                  return '0;
    endcase
  endfunction

  // driver: presents queued ticks, predicts on each transfer
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (tick_bus.valid && tick_bus.ready) begin
        verdict_q.push_back(supervise_tick('{tick_bus.fault_latched, tick_bus.output_enabled,
                                             tick_bus.loop_failed, tick_bus.fault_sources,
                                             tick_bus.bus_sample}));
        ticks_sent++;
      end
      if (!tick_bus.valid || tick_bus.ready) begin
        if (stim_q.size() > 0 && $urandom_range(99) >= send_gap_pct) begin
          next_tick = stim_q.pop_front();
          tick_bus.valid          <= 1'b1;
          tick_bus.fault_latched  <= next_tick.fault_latched;
          tick_bus.output_enabled <= next_tick.output_enabled;
          tick_bus.loop_failed    <= next_tick.loop_failed;
          tick_bus.fault_sources  <= next_tick.fault_sources;
          tick_bus.bus_sample     <= next_tick.bus_sample;
        end else begin
          tick_bus.valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (result_bus.valid && result_bus.ready) begin
        results_seen++;
        if (result_bus.action != frs_pkg::ACT_NONE) actions_seen++;
        if (result_bus.bus_updated) bus_fixes_seen++;
        if (verdict_q.size() == 0) begin
          $error("result transfer with no tick outstanding");
          fails++;
        end else begin
          want = verdict_q.pop_front();
          if (result_bus.action !== want.action) begin
            $error("action: expected %0d, got %0d", want.action, result_bus.action);
            fails++;
          end
          if (result_bus.bus_updated !== want.bus_updated) begin
            $error("bus_updated: expected %0d, got %0d", want.bus_updated,
                   result_bus.bus_updated);
            fails++;
          end
          if (result_bus.bus_value !== want.bus_value) begin
            $error("bus_value: expected %0d, got %0d", want.bus_value, result_bus.bus_value);
            fails++;
          end
          if (result_bus.blocked_code !== want.blocked_code) begin
            $error("blocked_code: expected %0d, got %0d", want.blocked_code,
                   result_bus.blocked_code);
            fails++;
          end
          if (result_bus.last_cause !== want.last_cause) begin
            $error("last_cause: expected %0d, got %0d", want.last_cause, result_bus.last_cause);
            fails++;
          end
          if (result_bus.actions_done !== want.actions_done) begin
            $error("actions_done: expected %0d, got %0d", want.actions_done,
                   result_bus.actions_done);
            fails++;
          end
        end
      end
      result_bus.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  task automatic check_readback(input logic [2:0] idx);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= {idx, 2'b00};
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    if (prdata !== mirror_value(idx)) begin
      $error("register %0d readback: expected %0h, got %0h", idx, mirror_value(idx), prdata);
      fails++;
    end
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic cfg_write(input logic [2:0] idx, input logic [31:0] val);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      frs_pkg::REG_START_DELAY: cfg.start_delay = val[15:0];
      frs_pkg::REG_COOLDOWN:    cfg.cooldown    = val[15:0];
      frs_pkg::REG_MAX_ACTIONS: cfg.max_actions = val[7:0];
      frs_pkg::REG_BOOT_WINDOW: cfg.boot_window = val[15:0];
      frs_pkg::REG_NOMINAL:     cfg.nominal     = val[15:0];
      frs_pkg::REG_FEATURES:    cfg.features    = val[3:0];
      default: ;
    endcase
    if (idx <= frs_pkg::REG_FEATURES) check_readback(idx);
  endtask

  task automatic write_settings(input logic [31:0] delay, input logic [31:0] cooldown,
                                input logic [31:0] budget, input logic [31:0] window,
                                input logic [31:0] nominal, input logic [31:0] features);
    cfg_write(frs_pkg::REG_START_DELAY, delay);
    cfg_write(frs_pkg::REG_COOLDOWN, cooldown);
    cfg_write(frs_pkg::REG_MAX_ACTIONS, budget);
    cfg_write(frs_pkg::REG_BOOT_WINDOW, window);
    cfg_write(frs_pkg::REG_NOMINAL, nominal);
    cfg_write(frs_pkg::REG_FEATURES, features);
    settings_used++;
  endtask

  task automatic queue_tick(input bit latched, input bit enabled, input bit failed,
                            input logic [7:0] sources, input logic [15:0] sample);
    stim_q.push_back('{latched, enabled, failed, sources, sample});
    ticks_queued++;
  endtask

  // waits until every queued tick has had its result
  task automatic settle();
    while (ticks_sent != ticks_queued || verdict_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic send_random(input int unsigned count);
    logic [7:0] src;
    for (int unsigned i = 0; i < count; i++) begin
      if (i == count / 2) settle();
      case ($urandom_range(9))
        0, 1, 2, 3: src = 8'h00;
        4:          src = $urandom_range(1) ? 8'h02 : 8'h08;
        5:          src = frs_pkg::HardSrcMask;
        default:    src = 8'($urandom);
      endcase
      queue_tick($urandom_range(99) < 40, $urandom_range(99) >= 30, $urandom_range(99) < 30,
                 src, 16'($urandom));
    end
    settle();
  endtask

  initial begin
    logic [31:0] n;
    logic [31:0] delay;
    logic [31:0] budget;
    rst_ni                  = 1'b0;
    psel                    = 1'b0;
    penable                 = 1'b0;
    pwrite                  = 1'b0;
    paddr                   = '0;
    pwdata                  = '0;
    tick_bus.valid          = 1'b0;
    tick_bus.fault_latched  = 1'b0;
    tick_bus.output_enabled = 1'b0;
    tick_bus.loop_failed    = 1'b0;
    tick_bus.fault_sources  = '0;
    tick_bus.bus_sample     = '0;
    result_bus.ready        = 1'b0;
    send_gap_pct   = 22;
    recv_stall_pct = 61;
    ticks_queued   = 0;
    ticks_sent     = 0;
    results_seen   = 0;
    actions_seen   = 0;
    bus_fixes_seen = 0;
    settings_used  = 0;
    fails          = 0;
    cfg = '{frs_pkg::RstStartDelay, frs_pkg::RstCooldown, frs_pkg::RstMaxActions,
            frs_pkg::RstBootWindow, frs_pkg::RstNominal, frs_pkg::RstFeatures};
    elapsed_ticks = '0;
    quiet_until   = '0;
    recoveries    = '0;
    bus_checked   = 1'b0;
    retry_spent   = 1'b0;
    last_refusal  = frs_pkg::ACT_NONE;
    last_reason   = frs_pkg::CAUSE_NONE;

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    for (int i = frs_pkg::REG_START_DELAY; i <= frs_pkg::REG_FEATURES; i++) begin
      check_readback(3'(i));
    end

    // start delay edge, priority order, hard/soft refusals, the single soft retry
    write_settings(4, 0, 0, 16'hFFFF, 16'hFFFF, 4'b1110);
    queue_tick(1, 1, 0, 8'h00, 16'h0000);
    queue_tick(0, 0, 0, 8'h00, 16'h1234);
    queue_tick(0, 1, 1, 8'h00, 16'h4321);
    queue_tick(1, 1, 0, 8'h00, 16'h0101);
    queue_tick(0, 0, 0, 8'h00, 16'h0202);
    queue_tick(0, 1, 1, 8'h00, 16'h0303);
    queue_tick(1, 0, 1, 8'h00, 16'h0404);
    queue_tick(1, 0, 1, 8'h04, 16'h0505);
    queue_tick(1, 0, 0, 8'h01, 16'h0606);
    queue_tick(1, 1, 0, 8'hF0, 16'h0707);
    queue_tick(1, 1, 0, 8'h02, 16'h0808);
    queue_tick(1, 1, 0, 8'h08, 16'h0909);
    queue_tick(0, 1, 0, 8'hFF, 16'hFFFF);
    settle();

    // one-time bus recheck, sample just above nominal plus margin
    write_settings(4, 2, 0, 16'hFFFF, 16'd6144, 4'b0001);
    queue_tick(1, 0, 1, 8'h00, 16'd6273);
    settle();

    // cooldown of two ticks
    write_settings(4, 2, 0, 16'hFFFF, 16'd6144, 4'hF);
    repeat (4) queue_tick(1, 1, 0, 8'h00, 16'h1000);
    settle();

    // budget exhausted; a write to an unmapped address must change nothing
    write_settings(4, 2, 1, 16'hFFFF, 16'd6144, 4'hF);
    cfg_write(RegUnmapped, 32'h0);
    queue_tick(1, 1, 0, 8'h00, 16'h2000);
    queue_tick(0, 0, 1, 8'h00, 16'h3000);
    settle();

    for (int phase = 0; phase < 8; phase++) begin
      send_gap_pct   = (phase < 3) ? 22 : (phase < 6) ? 61 : 0;
      recv_stall_pct = (phase < 3) ? 61 : (phase < 6) ? 22 : 0;
      case (phase)
        0: write_settings(0, 0, 0, 0, 0, 4'hF);
        1: write_settings('1, '1, '1, '1, '1, '1);
        2: write_settings(0, 0, 0, 0, 0, 0);
        default: begin
          n = elapsed_ticks + $urandom_range(40);
          delay = $urandom_range(1) ? 0 : ((n > 32'hFFFF) ? 32'hFFFF : n);
          case ($urandom_range(2))
            0: budget = 0;
            1: begin
              n = 32'(recoveries) + $urandom_range(1, 12);
              budget = (n > 32'd255) ? 32'd255 : n;
            end
            default: budget = $urandom_range(1, 255);
          endcase
          write_settings(delay, $urandom_range(6), budget, $urandom_range(16'hFFFF),
                         $urandom_range(16'hFFFF), $urandom_range(1, 15));
        end
      endcase
      send_random((phase == 1 || phase == 2) ? 30 : 110);
    end

    // run the action count up against the largest budget
    write_settings(0, 0, 255, 0, 0, 4'hF);
    repeat (300) queue_tick(1, $urandom_range(1), $urandom_range(1), 8'h00, 16'($urandom));
    settle();

    $display("%0d ticks checked over %0d register settings, idle and stall mixes included",
             results_seen, settings_used);
    $display("%0d recovery actions and %0d bus corrections seen; action count ended at %0d",
             actions_seen, bus_fixes_seen, recoveries);
    if (fails == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

[sim.f]
hw/rtl/frs_pkg.sv
hw/rtl/frs_if.sv
hw/rtl/frs_regs.sv
hw/rtl/fault_recovery_supervisor.sv
hw/rtl/frs_checker.sv
sim/fault_recovery_supervisor_tb.sv
